// ===== design/rrhp_pkg.sv =====
// ----------------------------------------------------------------------------
// rrhp_pkg: shared types and constants for the round-robin health picker
// Backend limits, function and status codes, register indexes, FSM states and
// the records passed between the controller and the health record memory.
// ----------------------------------------------------------------------------
package rrhp_pkg;

	// backend table limits
	localparam int MAX_BACKENDS = 16;
	localparam int IDX_W        = $clog2(MAX_BACKENDS);
	localparam int CNT_W        = $clog2(MAX_BACKENDS + 1);

	// field widths fixed by the interface
	localparam int TIME_W  = 32;
	localparam int FCNT_W  = 16;
	localparam int ENTRY_W = 4;
	localparam int CFG_W   = 32;
	localparam int REGIDX_W = 2;

	// request function codes
	typedef enum logic {
		FUNC_PICK  = 1'b0,
		FUNC_WRITE = 1'b1
	} func_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_HEALTHY    = 2'd0,
		STAT_ALL_DOWN   = 2'd1,
		STAT_NO_BACKEND = 2'd2,
		STAT_WRITE_DONE = 2'd3
	} status_t;

	// configuration register indexes
	localparam logic [REGIDX_W-1:0] REG_BACKEND_COUNT = 2'd0;
	localparam logic [REGIDX_W-1:0] REG_MAX_FAILS     = 2'd1;
	localparam logic [REGIDX_W-1:0] REG_FAIL_TIMEOUT  = 2'd2;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	// configuration as seen by the controller
	typedef struct packed {
		logic [CNT_W-1:0]  backend_count;
		logic [FCNT_W-1:0] strike_limit;
		logic [TIME_W-1:0] fail_timeout_ms;
	} cfg_t;

	// one backend's health record
	typedef struct packed {
		logic [FCNT_W-1:0] strikes;
		logic [TIME_W-1:0] last_fail_ms;
	} health_rec_t;

	// controller to memory access
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		health_rec_t      wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

endpackage

// ===== design/rrhp_req_if.sv =====
// ----------------------------------------------------------------------------
// rrhp_req_if: request channel
// Valid/ready channel carrying pick and health-record write requests.
// ----------------------------------------------------------------------------
interface rrhp_req_if;
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic [rrhp_pkg::TIME_W-1:0]  now_ms;
	logic [rrhp_pkg::ENTRY_W-1:0] entry_index;
	logic [rrhp_pkg::FCNT_W-1:0]  entry_fail_count;
	logic [rrhp_pkg::TIME_W-1:0]  entry_fail_time;

	modport source (
		output valid, func, now_ms, entry_index, entry_fail_count, entry_fail_time,
		input  ready
	);
	modport sink (
		input  valid, func, now_ms, entry_index, entry_fail_count, entry_fail_time,
		output ready
	);
endinterface

// ===== design/rrhp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rrhp_rsp_if: result channel
// Valid/ready channel carrying the chosen backend and a status code.
// ----------------------------------------------------------------------------
interface rrhp_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [rrhp_pkg::ENTRY_W-1:0] chosen_index;
	logic [1:0]                   status;

	modport source (
		output valid, chosen_index, status,
		input  ready
	);
	modport sink (
		input  valid, chosen_index, status,
		output ready
	);
endinterface

// ===== design/rrhp_health_mem.sv =====
// ----------------------------------------------------------------------------
// rrhp_health_mem: backend health record store
// One write port and one registered read port. Per-entry valid bits make
// never-written entries read back as an all-zero record.
// ----------------------------------------------------------------------------
module rrhp_health_mem (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rrhp_pkg::mem_req_t    req,
	output rrhp_pkg::health_rec_t rd_data
);

	rrhp_pkg::health_rec_t                 mem [rrhp_pkg::MAX_BACKENDS];
	logic [rrhp_pkg::MAX_BACKENDS-1:0]     valid_q;
	rrhp_pkg::health_rec_t                 rd_rec_s1;
	logic                                  rd_valid_s1;

	// record storage, no reset
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_rec_s1 <= mem[req.raddr];
		end
	end

	// written flags, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				rd_valid_s1 <= valid_q[req.raddr];
			end
		end
	end

	assign rd_data = rd_valid_s1 ? rd_rec_s1 : '0;

endmodule

// ===== design/rrhp_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrhp_ctrl: pick sequencer
// Takes requests, writes health records, reduces the cursor, scans backends
// through the record memory one per cycle and holds the result register.
// ----------------------------------------------------------------------------
module rrhp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rrhp_pkg::cfg_t        cfg,
	rrhp_req_if.sink              req,
	rrhp_rsp_if.source            rsp,
	output rrhp_pkg::mem_req_t    mem_req,
	input  rrhp_pkg::health_rec_t mem_rd_data
);

	rrhp_pkg::state_t state_q, state_d;

	logic [rrhp_pkg::IDX_W-1:0]   cursor_q;
	logic [rrhp_pkg::IDX_W-1:0]   slot_q;
	logic [rrhp_pkg::CNT_W-1:0]   issued_q;
	logic [rrhp_pkg::CNT_W-1:0]   checked_q;
	logic                         chk_valid_s1;
	logic [rrhp_pkg::IDX_W-1:0]   chk_slot_s1;
	logic [rrhp_pkg::TIME_W-1:0]  now_q;
	logic [rrhp_pkg::IDX_W-1:0]   res_idx_q;
	rrhp_pkg::status_t            res_status_q;
	logic                         out_valid_q;
	logic [rrhp_pkg::IDX_W-1:0]   out_idx_q;
	rrhp_pkg::status_t            out_status_q;

	logic [rrhp_pkg::CNT_W-1:0]   n_sat;
	logic                         in_beat;
	logic                         is_write;
	logic                         out_free;
	logic                         issue_more;
	logic [rrhp_pkg::TIME_W-1:0]  elapsed;
	logic                         penalty;
	logic                         check_hit;
	logic                         check_last;
	logic                         cursor_big;
	logic [rrhp_pkg::IDX_W-1:0]   slot_next;
	logic [rrhp_pkg::IDX_W-1:0]   hit_next;
	logic                         emit_load;

	// saturated backend count
	assign n_sat = (cfg.backend_count > rrhp_pkg::CNT_W'(rrhp_pkg::MAX_BACKENDS))
		? rrhp_pkg::CNT_W'(rrhp_pkg::MAX_BACKENDS) : cfg.backend_count;

	assign in_beat  = req.valid && req.ready;
	assign is_write = (rrhp_pkg::func_t'(req.func) == rrhp_pkg::FUNC_WRITE);
	assign out_free = !out_valid_q || rsp.ready;

	// cursor reduction and slot stepping with wrap at the count
	assign cursor_big = ({1'b0, cursor_q} >= n_sat);
	assign slot_next  = (({1'b0, slot_q} + 1'b1) == n_sat) ? '0 : slot_q + 1'b1;
	assign hit_next   = (({1'b0, chk_slot_s1} + 1'b1) == n_sat) ? '0 : chk_slot_s1 + 1'b1;
	assign issue_more = (issued_q < n_sat);

	// penalty window check on the record read last cycle
	assign elapsed = now_q - mem_rd_data.last_fail_ms;
	assign penalty = (cfg.strike_limit != '0)
		&& (mem_rd_data.strikes >= cfg.strike_limit)
		&& (mem_rd_data.last_fail_ms != '0)
		&& (elapsed < cfg.fail_timeout_ms);

	assign check_hit  = chk_valid_s1 && !penalty;
	assign check_last = chk_valid_s1 && penalty && ((checked_q + 1'b1) == n_sat);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rrhp_pkg::ST_IDLE: begin
				if (in_beat) begin
					if (is_write || (n_sat == '0)) begin
						state_d = rrhp_pkg::ST_EMIT;
					end else begin
						state_d = rrhp_pkg::ST_REDUCE;
					end
				end
			end
			rrhp_pkg::ST_REDUCE: begin
				if (!cursor_big) begin
					state_d = rrhp_pkg::ST_SCAN;
				end
			end
			rrhp_pkg::ST_SCAN: begin
				if (check_hit || check_last) begin
					state_d = rrhp_pkg::ST_EMIT;
				end
			end
			rrhp_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = rrhp_pkg::ST_IDLE;
				end
			end
			default: state_d = rrhp_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		req.ready           = (state_q == rrhp_pkg::ST_IDLE);
		mem_req.we          = in_beat && is_write
			&& ({1'b0, req.entry_index} < rrhp_pkg::CNT_W'(rrhp_pkg::MAX_BACKENDS));
		mem_req.waddr       = req.entry_index;
		mem_req.wdata.strikes      = req.entry_fail_count;
		mem_req.wdata.last_fail_ms = req.entry_fail_time;
		mem_req.re          = (state_q == rrhp_pkg::ST_SCAN) && issue_more;
		mem_req.raddr       = slot_q;
		emit_load           = (state_q == rrhp_pkg::ST_EMIT) && out_free;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rrhp_pkg::ST_IDLE;
			cursor_q     <= '0;
			issued_q     <= '0;
			checked_q    <= '0;
			chk_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			// cursor reduction and scan bookkeeping
			if (state_q == rrhp_pkg::ST_REDUCE) begin
				issued_q  <= '0;
				checked_q <= '0;
				if (cursor_big) begin
					cursor_q <= rrhp_pkg::IDX_W'({1'b0, cursor_q} - n_sat);
				end
			end
			if (state_q == rrhp_pkg::ST_SCAN) begin
				if (mem_req.re) begin
					issued_q <= issued_q + 1'b1;
				end
				if (chk_valid_s1 && penalty) begin
					checked_q <= checked_q + 1'b1;
				end
				if (check_hit) begin
					cursor_q <= hit_next;
				end
				chk_valid_s1 <= mem_req.re && !(check_hit || check_last);
			end else begin
				chk_valid_s1 <= 1'b0;
			end

			// result register
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			now_q <= req.now_ms;
			if (is_write) begin
				res_idx_q    <= req.entry_index;
				res_status_q <= rrhp_pkg::STAT_WRITE_DONE;
			end else begin
				res_idx_q    <= '0;
				res_status_q <= rrhp_pkg::STAT_NO_BACKEND;
			end
		end
		if ((state_q == rrhp_pkg::ST_REDUCE) && !cursor_big) begin
			slot_q <= cursor_q;
		end
		if (mem_req.re) begin
			slot_q      <= slot_next;
			chk_slot_s1 <= slot_q;
		end
		if ((state_q == rrhp_pkg::ST_SCAN) && check_hit) begin
			res_idx_q    <= chk_slot_s1;
			res_status_q <= rrhp_pkg::STAT_HEALTHY;
		end
		if ((state_q == rrhp_pkg::ST_SCAN) && check_last) begin
			res_idx_q    <= '0;
			res_status_q <= rrhp_pkg::STAT_ALL_DOWN;
		end
		if (emit_load) begin
			out_idx_q    <= res_idx_q;
			out_status_q <= res_status_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.chosen_index = out_idx_q;
	assign rsp.status       = out_status_q;

	// a record under check always belongs to a backend in use
	a_chk_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		chk_valid_s1 |-> ({1'b0, chk_slot_s1} < n_sat))
		else $error("checked slot outside backend count");

	// scanning starts only from a reduced cursor
	a_cursor_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rrhp_pkg::ST_SCAN) |-> ({1'b0, cursor_q} < n_sat))
		else $error("cursor not reduced during scan");

	// never more checks than backends
	a_check_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rrhp_pkg::ST_SCAN) |-> (checked_q < n_sat))
		else $error("scan checked more backends than configured");

	// the result register is loaded only when its previous beat is gone
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && out_valid_q) |-> rsp.ready)
		else $error("result overwritten before it was taken");

endmodule

// ===== design/round_robin_health_picker.sv =====
// ----------------------------------------------------------------------------
// round_robin_health_picker: round-robin backend picker with health skipping
// Top level: configuration registers, pick sequencer and health record store.
// ----------------------------------------------------------------------------
// One request is handled at a time. A health-record write goes from
// acceptance through the emit state to the result register, as does a pick
// with no backends. A pick runs r cursor reduction steps, then checks c
// backends (1 to count), one per cycle through the single read port of the
// record memory; r (at most 15) is zero unless the backend count was
// lowered to the cursor or below. The next request is taken
// while a finished result still waits in the output register. Skipping needs
// the fail limit register nonzero, the stored fail count at or above it, a
// nonzero fail time and (now_ms - fail time) mod 2^32 below fail_timeout_ms;
// if every backend is skipped the result is backend 0 with the all-down status.
module round_robin_health_picker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rrhp_pkg::REGIDX_W-1:0]   cfg_index,
	input  logic [rrhp_pkg::CFG_W-1:0]      cfg_data,
	rrhp_req_if.sink                        req,
	rrhp_rsp_if.source                      rsp
);

	rrhp_pkg::cfg_t        cfg_q;
	rrhp_pkg::mem_req_t    mem_req;
	rrhp_pkg::health_rec_t mem_rd_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rrhp_pkg::REG_BACKEND_COUNT:
					cfg_q.backend_count <= cfg_data[rrhp_pkg::CNT_W-1:0];
				rrhp_pkg::REG_MAX_FAILS:
					cfg_q.strike_limit <= cfg_data[rrhp_pkg::FCNT_W-1:0];
				rrhp_pkg::REG_FAIL_TIMEOUT:
					cfg_q.fail_timeout_ms <= cfg_data[rrhp_pkg::TIME_W-1:0];
				default: ;
			endcase
		end
	end

	rrhp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.req         (req),
		.rsp         (rsp),
		.mem_req     (mem_req),
		.mem_rd_data (mem_rd_data)
	);

	rrhp_health_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (mem_rd_data)
	);

endmodule
